>>> design/scpv_pkg.sv
// shared types, constants and codes for the pulse voice
`default_nettype none
package scpv_pkg;

	localparam int unsigned CLOCK_HZ_DEF = 985248;

	// divider operand width, covers the whole clock range up to 2 MHz
	localparam int unsigned DIV_W    = 21;
	localparam int unsigned PHASE_W  = 21;
	localparam int unsigned FREQ_W   = 16;
	localparam int unsigned WIDTH_W  = 16;
	localparam int unsigned FRAC_SH  = 12;
	localparam int unsigned PROD_W   = DIV_W + WIDTH_W;
	localparam int unsigned THR_W    = PROD_W - FRAC_SH;
	localparam int unsigned CNT_W    = $clog2(DIV_W + 1);

	// register addresses
	localparam logic [4:0] ADDR_FREQ_LO  = 5'd0;
	localparam logic [4:0] ADDR_FREQ_HI  = 5'd1;
	localparam logic [4:0] ADDR_WIDTH_LO = 5'd2;
	localparam logic [4:0] ADDR_WIDTH_HI = 5'd3;
	localparam logic [4:0] ADDR_CTRL     = 5'd4;

	// control byte bits
	localparam int unsigned GATE_BIT  = 0;
	localparam int unsigned PULSE_BIT = 6;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// sample codes
	localparam logic signed [1:0] SAMPLE_HIGH = 2'sb01;
	localparam logic signed [1:0] SAMPLE_LOW  = 2'sb11;
	localparam logic signed [1:0] SAMPLE_OFF  = 2'sb00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PERIOD,
		ST_MUL,
		ST_MOD,
		ST_EVAL,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic [WIDTH_W-1:0] width;
		logic               gate;
		logic               pulse;
	} voice_regs_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic              valid;
		logic signed [1:0] sample;
	} result_t;

endpackage
`default_nettype wire

>>> design/scpv_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module scpv_div (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire scpv_pkg::div_req_t req,
	output scpv_pkg::div_rsp_t rsp
);

	localparam int unsigned W = scpv_pkg::DIV_W;

	logic [W-1:0]                 q_q;
	logic [W-1:0]                 r_q;
	logic [W-1:0]                 d_q;
	logic [scpv_pkg::CNT_W-1:0]   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [W:0]                   trial;
	logic                         fits;

	assign trial = {r_q, q_q[W-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= scpv_pkg::CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == scpv_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			// shift in next dividend bit, subtract when it fits
			q_q <= {q_q[W-2:0], fits};
			r_q <= fits ? W'(trial - {1'b0, d_q}) : trial[W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;
	assign rsp.rem  = r_q;

endmodule
`default_nettype wire

>>> design/scpv_seq.sv
// tick sequencer: period, threshold, phase wrap and sample decision
`default_nettype none
module scpv_seq #(
	parameter int unsigned CLOCK_HZ = scpv_pkg::CLOCK_HZ_DEF
) (
	input  wire                   logic clk,
	input  wire                   logic arst_n,
	input  wire                   logic tick,
	input  wire scpv_pkg::voice_regs_t regs,
	input  wire                   logic slot_free,
	output logic                  idle,
	output scpv_pkg::result_t     res,
	output scpv_pkg::div_req_t    div_req,
	input  wire scpv_pkg::div_rsp_t div_rsp
);

	localparam int unsigned DW = scpv_pkg::DIV_W;
	localparam int unsigned PW = scpv_pkg::PHASE_W;

	scpv_pkg::seq_state_t        state_q, state_d;
	logic [DW-1:0]               period_q;
	logic [scpv_pkg::THR_W-1:0]  thr_q;
	logic [PW-1:0]               ph_q;
	logic [PW-1:0]               phase_q;
	logic signed [1:0]           sample_q;
	logic                        silent;
	logic                        phase_ok;
	logic [scpv_pkg::PROD_W-1:0] prod;
	logic [PW-1:0]               ph_inc;

	assign silent   = !regs.gate || !regs.pulse || (regs.freq == '0);
	assign phase_ok = DW'(phase_q) < period_q;
	assign prod     = scpv_pkg::PROD_W'(period_q) * scpv_pkg::PROD_W'(regs.width);
	assign ph_inc   = ph_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scpv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = DW'(CLOCK_HZ);
		div_req.divisor  = DW'(regs.freq);
		idle             = 1'b0;
		res.valid        = 1'b0;
		res.sample       = sample_q;
		case (state_q)
			scpv_pkg::ST_IDLE: begin
				idle = 1'b1;
				if (tick) begin
					if (silent) begin
						state_d = scpv_pkg::ST_DONE;
					end else begin
						div_req.start = 1'b1;
						state_d       = scpv_pkg::ST_PERIOD;
					end
				end
			end
			scpv_pkg::ST_PERIOD: begin
				if (div_rsp.done) begin
					state_d = (div_rsp.quot == '0) ? scpv_pkg::ST_DONE : scpv_pkg::ST_MUL;
				end
			end
			scpv_pkg::ST_MUL: begin
				// stale phase needs a modulo pass through the divider
				if (phase_ok) begin
					state_d = scpv_pkg::ST_EVAL;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = DW'(phase_q);
					div_req.divisor  = period_q;
					state_d          = scpv_pkg::ST_MOD;
				end
			end
			scpv_pkg::ST_MOD: begin
				if (div_rsp.done) begin
					state_d = scpv_pkg::ST_EVAL;
				end
			end
			scpv_pkg::ST_EVAL: begin
				state_d = scpv_pkg::ST_DONE;
			end
			scpv_pkg::ST_DONE: begin
				res.valid = 1'b1;
				if (slot_free) begin
					state_d = scpv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = scpv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (state_q == scpv_pkg::ST_EVAL) begin
			phase_q <= (DW'(ph_inc) == period_q) ? '0 : ph_inc;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			scpv_pkg::ST_IDLE: begin
				sample_q <= scpv_pkg::SAMPLE_OFF;
			end
			scpv_pkg::ST_PERIOD: begin
				period_q <= div_rsp.quot;
			end
			scpv_pkg::ST_MUL: begin
				thr_q <= prod[scpv_pkg::PROD_W-1:scpv_pkg::FRAC_SH];
				ph_q  <= phase_q;
			end
			scpv_pkg::ST_MOD: begin
				ph_q <= PW'(div_rsp.rem);
			end
			scpv_pkg::ST_EVAL: begin
				sample_q <= (scpv_pkg::THR_W'(ph_q) < thr_q) ?
					scpv_pkg::SAMPLE_HIGH : scpv_pkg::SAMPLE_LOW;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> design/sound_chip_pulse_voice_top.sv
// top level of the pulse voice: register file, tick sequencer, divider, output register
//
//  channel | signals                          | moves
//  --------+----------------------------------+-----------------------------------
//  input   | in_valid in_ready op addr data   | register write or one tick
//  output  | out_valid out_ready sample       | one sample per tick, none per write
//
// a register write leaves the block ready at once
// a tick makes one pass of the shared divider for the period, then steps through
//   the multiply, evaluate and done states; a second divider pass when the phase is not
//   below the period reduces it modulo the period, and a zero period goes straight to done
// silent ticks (gate or pulse off, zero frequency) skip the divider and go straight to done
// the sample waits in an output register; a stalled sink holds the next tick
//   in its last step, and in_ready drops while a tick is in work
// reset clears registers, phase and handshake state, no clearing pass
`default_nettype none
module sound_chip_pulse_voice_top #(
	parameter int unsigned CLOCK_HZ = scpv_pkg::CLOCK_HZ_DEF
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        in_valid,
	output logic              in_ready,
	input  wire  logic        op,
	input  wire  logic [4:0]  addr,
	input  wire  logic [7:0]  data,
	output logic              out_valid,
	input  wire  logic        out_ready,
	output logic signed [1:0] sample
);

	scpv_pkg::voice_regs_t regs_q;
	scpv_pkg::div_req_t    div_req;
	scpv_pkg::div_rsp_t    div_rsp;
	scpv_pkg::result_t     res;
	logic                  seq_idle;
	logic                  in_fire;
	logic                  wr_fire;
	logic                  tick_fire;
	logic                  slot_free;
	logic                  out_valid_q;
	logic signed [1:0]     sample_q;

	// input is taken whenever the sequencer is idle
	assign in_ready  = seq_idle;
	assign in_fire   = in_valid && in_ready;
	assign wr_fire   = in_fire && (op == scpv_pkg::OP_WRITE);
	assign tick_fire = in_fire && (op == scpv_pkg::OP_TICK);

	// output slot frees when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;

	// voice register file, writes outside the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wr_fire) begin
			case (addr)
				scpv_pkg::ADDR_FREQ_LO:  regs_q.freq[7:0]   <= data;
				scpv_pkg::ADDR_FREQ_HI:  regs_q.freq[15:8]  <= data;
				scpv_pkg::ADDR_WIDTH_LO: regs_q.width[7:0]  <= data;
				scpv_pkg::ADDR_WIDTH_HI: regs_q.width[15:8] <= data;
				scpv_pkg::ADDR_CTRL: begin
					regs_q.gate  <= data[scpv_pkg::GATE_BIT];
					regs_q.pulse <= data[scpv_pkg::PULSE_BIT];
				end
				default: begin
				end
			endcase
		end
	end

	scpv_seq #(
		.CLOCK_HZ(CLOCK_HZ)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_fire),
		.regs     (regs_q),
		.slot_free(slot_free),
		.idle     (seq_idle),
		.res      (res),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

	scpv_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && slot_free) begin
			sample_q <= res.sample;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule
`default_nettype wire

>>> design/scpv_checker.sv
// port-level checks for the pulse voice, bound to the top level
`default_nettype none
module scpv_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        op,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  sample
);

	// stalled sample holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample))
		else $error("sample changed while stalled");

	// only the three legal sample codes appear
	a_sample_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample != 2'b10)
		else $error("illegal sample code");

	// a register write leaves the block ready
	a_write_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == scpv_pkg::OP_WRITE) |=> in_ready)
		else $error("write left the block busy");

	// a tick occupies the sequencer and drops in_ready
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == scpv_pkg::OP_TICK) |=> !in_ready)
		else $error("tick did not occupy the sequencer");

endmodule

bind sound_chip_pulse_voice_top scpv_checker u_scpv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.op       (op),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.sample   (sample)
);
`default_nettype wire
